[rtl/core/igfr_pkg.sv]
// igfr_pkg: shared constants, types and helpers of the idle gap frame receiver
// used by every file of the block; depends on nothing
package igfr_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int ADDR_W    = 6;
	localparam int CAP_W     = 7;
	localparam int BYTE_W    = 8;
	localparam int STEP_W    = 3;
	localparam int SHIFT_W   = CAP_W + (1 << STEP_W) - 1;

	localparam logic [0:0] REG_IDLE_TICKS     = 1'b0;
	localparam logic [0:0] REG_FRAME_CAPACITY = 1'b1;

	localparam logic [BYTE_W-1:0] IDLE_TICKS_RST = 8'd10;
	localparam logic [CAP_W-1:0]  CAP_RST        = CAP_W'(BUF_DEPTH);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

	function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
		logic [CAP_W-1:0] r;
		r = v;
		if (v == '0)
			r = CAP_W'(1);
		else if (v > CAP_W'(BUF_DEPTH))
			r = CAP_W'(BUF_DEPTH);
		return r;
	endfunction

endpackage

[rtl/core/igfr_if.sv]
// igfr_in_if / igfr_out_if: valid-ready channels of the idle gap frame receiver
// depends on igfr_pkg
interface igfr_in_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [igfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface igfr_out_if;
	logic                        valid;
	logic                        ready;
	logic [igfr_pkg::BYTE_W-1:0] data_byte;
	logic [igfr_pkg::ADDR_W-1:0] frame_length;
	logic                        last;
	logic                        empty_res;

	modport source (output valid, output data_byte, output frame_length, output last,
		output empty_res, input ready);
	modport sink   (input valid, input data_byte, input frame_length, input last,
		input empty_res, output ready);
endinterface

[rtl/core/igfr_modstep.sv]
// igfr_modstep: shared compare-subtract unit, one restoring modulo step per cycle
// depends on igfr_pkg
module igfr_modstep (
	input  logic [igfr_pkg::CAP_W-1:0]  rem,
	input  logic [igfr_pkg::CAP_W-1:0]  divisor,
	input  logic [igfr_pkg::STEP_W-1:0] shift,
	output logic [igfr_pkg::CAP_W-1:0]  rem_next
);

	logic [igfr_pkg::SHIFT_W-1:0] div_sh;
	logic [igfr_pkg::SHIFT_W-1:0] rem_ext;
	logic                         ge;

	always_comb begin
		div_sh   = igfr_pkg::SHIFT_W'(divisor) << shift;
		rem_ext  = igfr_pkg::SHIFT_W'(rem);
		ge       = rem_ext >= div_sh;
		rem_next = ge ? (rem - div_sh[igfr_pkg::CAP_W-1:0]) : rem;
	end

endmodule

[rtl/core/igfr_store.sv]
// igfr_store: frame byte memory, one write and one registered read port
// depends on igfr_pkg
module igfr_store (
	input  logic                        clk,
	input  igfr_pkg::store_wr_t         wr,
	input  igfr_pkg::store_rd_t         rd,
	output logic [igfr_pkg::BYTE_W-1:0] rd_data
);

	logic [igfr_pkg::BYTE_W-1:0] mem [igfr_pkg::BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd.re)
			rd_data <= mem[rd.addr];
	end

endmodule

[rtl/core/idle_gap_frame_receiver.sv]
// idle_gap_frame_receiver: top level, sequencer, timer, config registers, output register
// depends on igfr_pkg, igfr_if, igfr_modstep, igfr_store
//
// channel   dir   fields                                        request
// in_ch     in    mode, rx_byte                                 byte or timer tick
// out_ch    out   data_byte, frame_length, last, empty_res      one byte of a frame result
// cfg       in    cfg_we, cfg_index, cfg_data                   register write
//
// byte request: the byte is stored, then 7 steps of the shared compare-subtract unit
// for the fill position wrap
// tick without a ready frame: handled in the idle state alone; with a frame: per byte a memory
// read, then an output register load; an empty frame takes only the load; out_ch stalls delay it
// out_ch stalls hold the output register; in_ch is accepted only while the sequencer idles
// arst_n clears all control state; the frame memory is not cleared
module idle_gap_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	igfr_in_if.sink                     in_ch,
	igfr_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [igfr_pkg::BYTE_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0]                  state_q;
	logic [igfr_pkg::ADDR_W-1:0] fill_q;
	logic [igfr_pkg::BYTE_W-1:0] timer_q;
	logic                        ready_q;
	logic [igfr_pkg::BYTE_W-1:0] idle_ticks_q;
	logic [igfr_pkg::CAP_W-1:0]  cap_q;
	logic [igfr_pkg::CAP_W-1:0]  rem_q;
	logic [igfr_pkg::STEP_W-1:0] step_q;
	logic [igfr_pkg::ADDR_W-1:0] len_q;
	logic [igfr_pkg::ADDR_W-1:0] idx_q;
	logic                        empty_q;

	logic                        out_valid_q;
	logic [igfr_pkg::BYTE_W-1:0] out_data_q;
	logic [igfr_pkg::ADDR_W-1:0] out_len_q;
	logic                        out_last_q;
	logic                        out_empty_q;

	logic                        in_fire;
	logic                        out_free;
	logic                        load_fire;
	logic                        is_last;
	logic                        timer_set;
	logic [igfr_pkg::CAP_W-1:0]  rem_next;
	logic [igfr_pkg::BYTE_W-1:0] rd_data;
	igfr_pkg::store_wr_t         st_wr;
	igfr_pkg::store_rd_t         st_rd;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign load_fire   = (state_q == ST_LOAD) && out_free;
	assign is_last     = empty_q || (idx_q == (len_q - igfr_pkg::ADDR_W'(1)));
	assign timer_set   = (timer_q == 8'd1) || (timer_q == 8'd2);

	assign st_wr.we   = in_fire && !in_ch.mode;
	assign st_wr.addr = fill_q;
	assign st_wr.data = in_ch.rx_byte;
	assign st_rd.re   = (state_q == ST_READ);
	assign st_rd.addr = idx_q;

	igfr_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.rd      (st_rd),
		.rd_data (rd_data)
	);

	igfr_modstep u_modstep (
		.rem      (rem_q),
		.divisor  (cap_q),
		.shift    (step_q),
		.rem_next (rem_next)
	);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.data_byte    = out_data_q;
	assign out_ch.frame_length = out_len_q;
	assign out_ch.last         = out_last_q;
	assign out_ch.empty_res    = out_empty_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= igfr_pkg::IDLE_TICKS_RST;
			cap_q        <= igfr_pkg::CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				igfr_pkg::REG_IDLE_TICKS:     idle_ticks_q <= cfg_data;
				igfr_pkg::REG_FRAME_CAPACITY:
					cap_q <= igfr_pkg::clamp_cap(cfg_data[igfr_pkg::CAP_W-1:0]);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			timer_q <= '0;
			ready_q <= 1'b0;
			rem_q   <= '0;
			step_q  <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			empty_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && !in_ch.mode) begin
						timer_q <= idle_ticks_q;
						rem_q   <= igfr_pkg::CAP_W'(fill_q) + igfr_pkg::CAP_W'(1);
						step_q  <= igfr_pkg::STEP_W'(igfr_pkg::CAP_W - 1);
						state_q <= ST_MOD;
					end else if (in_fire) begin
						ready_q <= timer_set;
						if (timer_set)
							timer_q <= '0;
						else if (timer_q > 8'd2)
							timer_q <= timer_q - 8'd1;
						if (ready_q) begin
							len_q   <= fill_q;
							fill_q  <= '0;
							idx_q   <= '0;
							empty_q <= (fill_q == '0);
							state_q <= (fill_q == '0) ? ST_LOAD : ST_READ;
						end
					end
				end
				ST_MOD: begin
					rem_q  <= rem_next;
					step_q <= step_q - igfr_pkg::STEP_W'(1);
					if (step_q == '0) begin
						fill_q  <= rem_next[igfr_pkg::ADDR_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (out_free) begin
						idx_q   <= idx_q + igfr_pkg::ADDR_W'(1);
						state_q <= is_last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire) begin
			out_data_q  <= empty_q ? '0 : rd_data;
			out_len_q   <= len_q;
			out_last_q  <= is_last;
			out_empty_q <= empty_q;
		end
	end

endmodule

[rtl/core/igfr_chk.sv]
// igfr_chk: port-level checks of the idle gap frame receiver, bound to the top level
// depends on igfr_pkg
module igfr_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [igfr_pkg::BYTE_W-1:0] data_byte,
	input logic [igfr_pkg::ADDR_W-1:0] frame_length,
	input logic                        last,
	input logic                        empty_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_byte) && $stable(frame_length)
			&& $stable(last) && $stable(empty_res))
		else $error("result changed while stalled");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && (frame_length == '0))
		else $error("empty result malformed");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_res |-> (frame_length != '0))
		else $error("data result with zero length");

	a_busy_midframe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request taken in the middle of a frame");

endmodule

bind idle_gap_frame_receiver igfr_chk u_igfr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.data_byte    (out_ch.data_byte),
	.frame_length (out_ch.frame_length),
	.last         (out_ch.last),
	.empty_res    (out_ch.empty_res)
);
